>>> sv/json_string_unescape_utf8_assert.svh
// assertion macros for the string unescaper
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define JSU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu assertion failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu assertion failed");

`else

`define JSU_ASSERT_IMP(label, clk, rst, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/jsu_pkg.sv
package jsu_pkg;

  // input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_flag;
  } in_t;

  // one result
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [3:0] err_code;
    logic       last;
  } out_t;

  // all results caused by one request
  typedef struct packed {
    logic [2:0]      cnt;
    logic [1:0]      kind;
    logic [3:0]      err;
    logic [3:0][7:0] bytes;
  } bund_t;

  // parser phases
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_BODY   = 7'b0000010,
    PH_ESC    = 7'b0000100,
    PH_HEX1   = 7'b0001000,
    PH_WANTBS = 7'b0010000,
    PH_WANTU  = 7'b0100000,
    PH_HEX2   = 7'b1000000
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_NO_OPEN   = 4'd1;
  localparam logic [3:0] ERR_CTRL      = 4'd2;
  localparam logic [3:0] ERR_ESC       = 4'd3;
  localparam logic [3:0] ERR_HEX       = 4'd4;
  localparam logic [3:0] ERR_HIGH_ONLY = 4'd5;
  localparam logic [3:0] ERR_BAD_PAIR  = 4'd6;
  localparam logic [3:0] ERR_LOW_ONLY  = 4'd7;
  localparam logic [3:0] ERR_UNTERM    = 4'd8;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // single result carrying one byte
  function automatic bund_t mk_one(input logic [1:0] kind, input logic [3:0] err,
                                   input logic [7:0] b);
    bund_t r;
    r          = '0;
    r.cnt      = 3'd1;
    r.kind     = kind;
    r.err      = err;
    r.bytes[0] = b;
    return r;
  endfunction

  // hex digit check and value
  function automatic logic hex_ok(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // utf-8 encoding of one code point
  function automatic bund_t utf8_enc(input logic [20:0] cp);
    bund_t r;
    r      = '0;
    r.kind = KIND_BYTE;
    r.err  = ERR_NONE;
    if (cp <= 21'h7f) begin
      r.cnt      = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      r.cnt      = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      r.cnt      = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt      = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

>>> sv/jsu_decode.sv
module jsu_decode import jsu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  in_t   item,
  output bund_t res
);

  phase_t      phase, phase_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [9:0]  high_part, high_part_next;

  logic [7:0]  c;
  logic [15:0] quad;
  logic        hv;

  assign c    = item.in_byte;
  assign hv   = hex_ok(c);
  assign quad = {hex_accum[11:0], hex_val(c)};

  // next state and result bundle
  always_comb begin
    phase_next       = phase;
    hex_accum_next   = hex_accum;
    digit_count_next = digit_count;
    high_part_next   = high_part;
    res              = '0;
    if (item.end_flag) begin
      if (phase != PH_IDLE) begin
        phase_next = PH_IDLE;
        res        = mk_one(KIND_ERR, ERR_UNTERM, 8'h00);
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (c == CH_QUOTE) begin
            phase_next = PH_BODY;
          end else begin
            res = mk_one(KIND_ERR, ERR_NO_OPEN, 8'h00);
          end
        end
        PH_BODY: begin
          if (c == CH_QUOTE) begin
            phase_next = PH_IDLE;
            res        = mk_one(KIND_DONE, ERR_NONE, 8'h00);
          end else if (c < CH_SPACE) begin
            phase_next = PH_IDLE;
            res        = mk_one(KIND_ERR, ERR_CTRL, 8'h00);
          end else if (c == CH_BSL) begin
            phase_next = PH_ESC;
          end else begin
            res = mk_one(KIND_BYTE, ERR_NONE, c);
          end
        end
        PH_ESC: begin
          phase_next = PH_BODY;
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: res = mk_one(KIND_BYTE, ERR_NONE, c);
            CH_B: res = mk_one(KIND_BYTE, ERR_NONE, 8'h08);
            CH_F: res = mk_one(KIND_BYTE, ERR_NONE, 8'h0c);
            CH_N: res = mk_one(KIND_BYTE, ERR_NONE, 8'h0a);
            CH_R: res = mk_one(KIND_BYTE, ERR_NONE, 8'h0d);
            CH_T: res = mk_one(KIND_BYTE, ERR_NONE, 8'h09);
            CH_U: begin
              phase_next       = PH_HEX1;
              hex_accum_next   = '0;
              digit_count_next = '0;
            end
            default: begin
              phase_next = PH_IDLE;
              res        = mk_one(KIND_ERR, ERR_ESC, 8'h00);
            end
          endcase
        end
        PH_HEX1: begin
          if (!hv) begin
            phase_next = PH_IDLE;
            res        = mk_one(KIND_ERR, ERR_HEX, 8'h00);
          end else begin
            hex_accum_next = quad;
            if (digit_count == 2'd3) begin
              digit_count_next = '0;
              if (quad inside {[16'hd800:16'hdbff]}) begin
                // high surrogate: keep its low ten bits
                high_part_next = quad[9:0];
                phase_next     = PH_WANTBS;
              end else if (quad inside {[16'hdc00:16'hdfff]}) begin
                phase_next = PH_IDLE;
                res        = mk_one(KIND_ERR, ERR_LOW_ONLY, 8'h00);
              end else begin
                phase_next = PH_BODY;
                res        = utf8_enc({5'd0, quad});
              end
            end else begin
              digit_count_next = digit_count + 2'd1;
            end
          end
        end
        PH_WANTBS: begin
          if (c == CH_BSL) begin
            phase_next = PH_WANTU;
          end else begin
            phase_next = PH_IDLE;
            res        = mk_one(KIND_ERR, ERR_HIGH_ONLY, 8'h00);
          end
        end
        PH_WANTU: begin
          if (c == CH_U) begin
            phase_next       = PH_HEX2;
            hex_accum_next   = '0;
            digit_count_next = '0;
          end else begin
            phase_next = PH_IDLE;
            res        = mk_one(KIND_ERR, ERR_HIGH_ONLY, 8'h00);
          end
        end
        PH_HEX2: begin
          if (!hv) begin
            phase_next = PH_IDLE;
            res        = mk_one(KIND_ERR, ERR_HEX, 8'h00);
          end else begin
            hex_accum_next = quad;
            if (digit_count == 2'd3) begin
              digit_count_next = '0;
              if (quad inside {[16'hdc00:16'hdfff]}) begin
                // join the pair into a supplementary code point
                phase_next = PH_BODY;
                res        = utf8_enc(21'h10000 + {1'b0, high_part, quad[9:0]});
              end else begin
                phase_next = PH_IDLE;
                res        = mk_one(KIND_ERR, ERR_BAD_PAIR, 8'h00);
              end
            end else begin
              digit_count_next = digit_count + 2'd1;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      hex_accum   <= '0;
      digit_count <= '0;
      high_part   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      hex_accum   <= hex_accum_next;
      digit_count <= digit_count_next;
      high_part   <= high_part_next;
    end
  end

endmodule

>>> sv/jsu_emit.sv
module jsu_emit import jsu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load_valid,
  input  bund_t load_data,
  output logic  hold,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_item
);

  logic       occ;
  logic [1:0] idx;
  bund_t      bund;
  logic       is_last;
  logic       drain;
  logic       load;

  assign is_last = (({1'b0, idx} + 3'd1) == bund.cnt);
  assign drain   = occ && !out_stall;
  assign load    = load_valid && (load_data.cnt != 3'd0);

  // upstream waits while a bundle is held, unless it empties this cycle
  assign hold = occ && !(is_last && !out_stall);

  // result register
  assign out_valid         = occ;
  assign out_item.out_byte = bund.bytes[idx];
  assign out_item.out_kind = bund.kind;
  assign out_item.err_code = bund.err;
  assign out_item.last     = is_last;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      idx <= '0;
    end else if (load) begin
      occ <= 1'b1;
      idx <= '0;
    end else if (drain && is_last) begin
      occ <= 1'b0;
      idx <= '0;
    end else if (drain) begin
      idx <= idx + 2'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      bund <= load_data;
    end
  end

endmodule

>>> sv/json_string_unescape_utf8.sv
// latency: first result is valid the cycle after the request is taken
// throughput: one input byte per cycle while the output is not stalled; a code point of n
//   utf-8 bytes stalls the input until its last byte is sent, and input is taken again then
// rate is set by the single result register that sends one byte per cycle unless out_stall
// reset: synchronous, clears the parser to waiting for an opening quote
`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  logic  in_accept;
  bund_t res;

  assign in_accept = in_valid && !in_stall;

  // parser
  jsu_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .item   (in_item),
    .res    (res)
  );

  // result serializer
  jsu_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_accept),
    .load_data  (res),
    .hold       (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  // checks
  `JSU_ASSERT_IMP(a_err_code_kind, clk, rst, out_valid,
    ((out_item.out_kind == KIND_ERR) == (out_item.err_code != ERR_NONE)))
  `JSU_ASSERT_IMP(a_status_single, clk, rst, out_valid && (out_item.out_kind != KIND_BYTE),
    out_item.last && (out_item.out_byte == 8'h00))
  `JSU_ASSERT_IMP(a_hold_mid_seq, clk, rst, out_valid && !out_item.last, in_stall)
  `JSU_ASSERT_NEXT(a_seq_continues, clk, rst, out_valid && !out_stall && !out_item.last,
    out_valid)

endmodule

>>> verif/jsu_unescape_check.sv
`timescale 1ns / 1ps

module jsu_unescape_check import jsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_item,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_item,
  output int   pending,
  output int   errors
);

  // shadow copy of the parser state
  phase_t      ph      = PH_IDLE;
  logic [15:0] quad    = '0;
  logic [1:0]  ndig    = '0;
  logic [9:0]  hi_bits = '0;

  out_t decoded_q[$];  // results still owed by the block, oldest first
  out_t step_res[$];   // results of the request being decoded
  int   queued = 0;
  int   mism   = 0;

  assign pending = queued;
  assign errors  = mism;

  // one line per mismatch
  task automatic flag_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    $display("%0t mismatch %s: want %0h got %0h", $time, what, want, got);
    mism++;
  endtask

  // value of a hex digit, -1 when not a hex digit
  function automatic int digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic add_res(input logic [7:0] b, input logic [1:0] k, input logic [3:0] e);
    out_t r;
    r.out_byte = b;
    r.out_kind = k;
    r.err_code = e;
    r.last     = 1'b0;
    step_res = {step_res, r};
  endtask

  task automatic raise_err(input logic [3:0] e);
    ph = PH_IDLE;
    add_res(8'h00, KIND_ERR, e);
  endtask

  // utf-8 bytes of one code point
  task automatic add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_res(cp[7:0], KIND_BYTE, ERR_NONE);
    end else if (cp < 21'h800) begin
      add_res(8'hc0 | 8'(cp >> 6), KIND_BYTE, ERR_NONE);
      add_res(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE);
    end else if (cp < 21'h10000) begin
      add_res(8'he0 | 8'(cp >> 12), KIND_BYTE, ERR_NONE);
      add_res(8'h80 | 8'((cp >> 6) & 21'h3f), KIND_BYTE, ERR_NONE);
      add_res(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE);
    end else begin
      add_res(8'hf0 | 8'((cp >> 18) & 21'h07), KIND_BYTE, ERR_NONE);
      add_res(8'h80 | 8'((cp >> 12) & 21'h3f), KIND_BYTE, ERR_NONE);
      add_res(8'h80 | 8'((cp >> 6) & 21'h3f), KIND_BYTE, ERR_NONE);
      add_res(8'h80 | 8'(cp & 21'h3f), KIND_BYTE, ERR_NONE);
    end
  endtask

  // a hex digit inside a \u quad; acts once the fourth digit is in
  task automatic take_digit(input logic [7:0] c);
    int d;
    d = digit_of(c);
    if (d < 0) begin
      raise_err(ERR_HEX);
    end else begin
      quad = {quad[11:0], 4'(d)};
      if (ndig != 2'd3) begin
        ndig = ndig + 2'd1;
      end else begin
        ndig = 2'd0;
        if (ph == PH_HEX1) begin
          if (quad inside {[16'hd800:16'hdbff]}) begin
            hi_bits = quad[9:0];
            ph      = PH_WANTBS;
          end else if (quad inside {[16'hdc00:16'hdfff]}) begin
            raise_err(ERR_LOW_ONLY);
          end else begin
            ph = PH_BODY;
            add_code_point({5'd0, quad});
          end
        end else if (!(quad inside {[16'hdc00:16'hdfff]})) begin
          raise_err(ERR_BAD_PAIR);
        end else begin
          ph = PH_BODY;
          add_code_point(21'h10000 + {1'b0, hi_bits, quad[9:0]});
        end
      end
    end
  endtask

  // expected results of one request, appended to the owed results
  task automatic decode_request(input in_t r);
    logic [7:0] c;
    c = r.in_byte;
    step_res.delete();
    if (r.end_flag) begin
      if (ph != PH_IDLE) raise_err(ERR_UNTERM);
    end else begin
      case (ph)
        PH_IDLE: begin
          if (c == CH_QUOTE) ph = PH_BODY;
          else raise_err(ERR_NO_OPEN);
        end
        PH_BODY: begin
          if (c == CH_QUOTE) begin
            ph = PH_IDLE;
            add_res(8'h00, KIND_DONE, ERR_NONE);
          end else if (c < CH_SPACE) begin
            raise_err(ERR_CTRL);
          end else if (c == CH_BSL) begin
            ph = PH_ESC;
          end else begin
            add_res(c, KIND_BYTE, ERR_NONE);
          end
        end
        PH_ESC: begin
          ph = PH_BODY;
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: add_res(c, KIND_BYTE, ERR_NONE);
            CH_B: add_res(8'h08, KIND_BYTE, ERR_NONE);
            CH_F: add_res(8'h0c, KIND_BYTE, ERR_NONE);
            CH_N: add_res(8'h0a, KIND_BYTE, ERR_NONE);
            CH_R: add_res(8'h0d, KIND_BYTE, ERR_NONE);
            CH_T: add_res(8'h09, KIND_BYTE, ERR_NONE);
            CH_U: begin
              ph   = PH_HEX1;
              quad = '0;
              ndig = '0;
            end
            default: raise_err(ERR_ESC);
          endcase
        end
        PH_HEX1, PH_HEX2: take_digit(c);
        PH_WANTBS: begin
          if (c != CH_BSL) raise_err(ERR_HIGH_ONLY);
          else ph = PH_WANTU;
        end
        PH_WANTU: begin
          if (c != CH_U) begin
            raise_err(ERR_HIGH_ONLY);
          end else begin
            ph   = PH_HEX2;
            quad = '0;
            ndig = '0;
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) decoded_q = {decoded_q, step_res[i]};
  endtask

  // compare one result against the oldest owed one
  task automatic check_result(input out_t got);
    out_t want;
    if (decoded_q.size() == 0) begin
      flag_mismatch("result with nothing owed, byte", 8'h00, got.out_byte);
    end else begin
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte)
        flag_mismatch("out_byte", want.out_byte, got.out_byte);
      if (got.out_kind !== want.out_kind)
        flag_mismatch("out_kind", {6'd0, want.out_kind}, {6'd0, got.out_kind});
      if (got.err_code !== want.err_code)
        flag_mismatch("err_code", {4'd0, want.err_code}, {4'd0, got.err_code});
      if (got.last !== want.last)
        flag_mismatch("last", {7'd0, want.last}, {7'd0, got.last});
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      ph      = PH_IDLE;
      quad    = '0;
      ndig    = '0;
      hi_bits = '0;
      decoded_q.delete();
      queued <= 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      if (in_valid && !in_stall) decode_request(in_item);
      queued <= decoded_q.size();
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 72;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_item;
  logic out_valid;
  logic out_stall;
  out_t out_item;
  int   pending;
  int   errors;

  int idle_pct  = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int quiet = 0;

  logic [7:0] esc_set [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

  json_string_unescape_utf8 i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  jsu_unescape_check i_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .pending  (pending),
    .errors   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // give up after a long stretch with no request or result moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // hex digit in random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (($urandom_range(1) != 0) ? 8'h61 : 8'h41) + 8'(v - 4'd10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom); while (is_hex(c));
    return c;
  endfunction

  // code point outside the surrogate range, spread over utf-8 lengths
  function automatic logic [15:0] plain_code();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h7f));
      1: return 16'($urandom_range(16'h7ff, 16'h80));
      2: return 16'($urandom_range(16'hd7ff, 16'h800));
      default: return 16'($urandom_range(16'hffff, 16'he000));
    endcase
  endfunction

  function automatic logic [15:0] high_half();
    return 16'hd800 | 16'($urandom_range(1023));
  endfunction

  function automatic logic [15:0] low_half();
    return 16'hdc00 | 16'($urandom_range(1023));
  endfunction

  // one request, with an optional sender gap in front
  task automatic send(input logic [7:0] b, input logic e);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid         <= 1'b1;
    in_item.in_byte  <= b;
    in_item.end_flag <= e;
    do @(posedge clk); while (in_stall);
    if (!e) bytes_sent++;
  endtask

  task automatic send_end();
    send(8'($urandom), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  task automatic send_digits(input logic [15:0] v, input int n);
    for (int i = 0; i < n; i++) send(hex_char(v[15 - 4 * i -: 4]), 1'b0);
  endtask

  task automatic send_quad(input logic [15:0] v);
    send(CH_BSL, 1'b0);
    send(CH_U, 1'b0);
    send_digits(v, 4);
  endtask

  // well-formed piece of a literal body
  task automatic send_good_element();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        do c = 8'($urandom_range(255, 32)); while (c == CH_QUOTE || c == CH_BSL);
        send(c, 1'b0);
      end
      4, 5: begin
        send(CH_BSL, 1'b0);
        send(esc_set[$urandom_range(7)], 1'b0);
      end
      6, 7: send_quad(plain_code());
      default: begin
        send_quad(high_half());
        send_quad(low_half());
      end
    endcase
  endtask

  // broken ending of a literal
  task automatic send_fault();
    logic [7:0]  c;
    logic [15:0] v;
    int          n;
    case ($urandom_range(8))
      0: begin
        // input runs out, possibly in the middle of an escape
        n = $urandom_range(5);
        if (n > 0) send(CH_BSL, 1'b0);
        if (n > 1) send(CH_U, 1'b0);
        if (n > 2) send_digits(plain_code(), n - 2);
        send_end();
      end
      1: send(8'($urandom_range(31)), 1'b0);
      2: begin
        send(CH_BSL, 1'b0);
        do c = 8'($urandom);
        while (c inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        send(c, 1'b0);
      end
      3: begin
        send(CH_BSL, 1'b0);
        send(CH_U, 1'b0);
        send_digits(16'($urandom), $urandom_range(3));
        send(non_hex(), 1'b0);
      end
      4: begin
        // high half not followed by a second \u escape
        send_quad(high_half());
        if ($urandom_range(1) != 0) begin
          do c = 8'($urandom); while (c == CH_BSL);
        end else begin
          send(CH_BSL, 1'b0);
          do c = 8'($urandom); while (c == CH_U);
        end
        send(c, 1'b0);
      end
      5: begin
        send_quad(high_half());
        do v = 16'($urandom); while (v inside {[16'hdc00:16'hdfff]});
        send_quad(v);
      end
      6: send_quad(low_half());
      7: begin
        send_quad(high_half());
        send(CH_BSL, 1'b0);
        send(CH_U, 1'b0);
        send_digits(16'($urandom), $urandom_range(3));
        send(non_hex(), 1'b0);
      end
      default: begin
        // raw noise, then an end to get back to waiting
        repeat ($urandom_range(4, 1)) send(8'($urandom), $urandom_range(3) == 0);
        send_end();
      end
    endcase
  endtask

  // mostly well-formed literals with random content
  task automatic send_literal();
    int   n;
    logic broken;
    broken = ($urandom_range(99) < 30);
    n      = $urandom_range(broken ? 3 : 8);
    send(CH_QUOTE, 1'b0);
    repeat (n) send_good_element();
    if (broken) send_fault();
    else send(CH_QUOTE, 1'b0);
  endtask

  task automatic n_loop(input int target);
    while (bytes_sent < target) send_literal();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: idle cases, byte extremes, bad escape, \u0000, top code point, cut off
    send_end();
    send_text("A");
    send_text("\"");
    send(8'h00, 1'b0);
    send_text("\"");
    send(8'hff, 1'b0);
    send_text("\\q");
    send_text("\"\\u0000\\uDBFF\\udFfF");
    send_end();

    // random literals under each idling mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      n_loop(bytes_sent + ITEMS_PER_PHASE);
    end
    in_valid <= 1'b0;

    // drain
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
